// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL in this folder.
// NSM_ASSERT_IMP expects i_clk and i_rst_n in scope; NSM_ASSERT_NXT needs only i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define NSM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nsm check failed");

// Next-cycle implication, also checked across reset
`define NSM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("nsm check failed");

`endif

// ===== rtl/core/nsm_pkg.sv =====
`timescale 1ns / 1ps

package nsm_pkg;

    // Input selection codes
    typedef enum logic [1:0] {
        OP_PHASE   = 2'd0,
        OP_DERIVED = 2'd1,
        OP_LINE    = 2'd2
    } t_op;

    // 0.866 approximated as 433/500, rounded half away from zero
    localparam int unsigned K_NUM  = 433;
    localparam int unsigned K_HALF = 250;
    localparam int unsigned K_DEN  = 500;
    // Divide by 500 as a shift by two, then a divide by 125
    localparam int unsigned K_DIV4      = K_DEN / 4;
    localparam int unsigned RECIP_SHIFT = 30;
    localparam int unsigned RECIP_M     = (2 ** RECIP_SHIFT) / K_DIV4;

    // Pipeline shape: six arithmetic stages, one load stage, one stage per root bit
    localparam int unsigned SQRT_STEPS = 16;
    localparam int unsigned PIPE_DEPTH = 7 + SQRT_STEPS;

    // Sign-extend a phasor component by one bit
    function automatic logic signed [16:0] sx17(input logic signed [15:0] v);
        return $signed({v[15], v});
    endfunction

    // Halve, truncating toward zero
    function automatic logic signed [16:0] half_tz(input logic signed [16:0] s);
        logic signed [16:0] t;
        t = s + $signed({16'b0, s[16]});
        return t >>> 1;
    endfunction

endpackage

// ===== rtl/core/negative_sequence_magnitude.sv =====
`timescale 1ns / 1ps
// Negative-sequence phasor and magnitude.
// Input channel: i_valid / o_stall with i_operation and three phasors, each as
// real and imaginary part. An item is taken at a rising edge with i_valid high
// and o_stall low. Operation 0 takes phases A, B and C, operation 1 derives B
// from A and C, operation 2 takes the line phasors AB and BC; code 3 acts as 0.
// Output channel: o_valid / i_stall with o_neg_real, o_neg_imag (wrapped to
// 16 bits) and o_magnitude, the floor square root of their squared sum.
// Six stages form the phasor and its squares (difference terms, scaling by 433,
// reciprocal divide by 500, quotient correction, final add, squaring), one stage
// adds the squares and sixteen stages each settle one bit of the root. One item
// is taken per cycle while o_stall is low.
// Reset clears every valid bit; nothing else is held, so no result survives it.
// While o_valid is high and i_stall is high the whole pipeline holds and
// o_stall goes high; empty stages do not close up during a stall.
`include "assert_macros.svh"

module negative_sequence_magnitude import nsm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [15:0] i_first_real,
    input  logic signed [15:0] i_first_imag,
    input  logic signed [15:0] i_second_real,
    input  logic signed [15:0] i_second_imag,
    input  logic signed [15:0] i_third_real,
    input  logic signed [15:0] i_third_imag,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_neg_real,
    output logic signed [15:0] o_neg_imag,
    output logic [15:0]        o_magnitude
);

    logic                  w_adv;
    logic [PIPE_DEPTH-1:0] r_vld;

    // Stage 1: base terms and magnitudes of the difference terms
    logic signed [15:0] r1_base_r, r1_base_x, n1_base_r, n1_base_x;
    logic               r1_neg_r, r1_neg_x, n1_neg_r, n1_neg_x;
    logic [15:0]        r1_abs_r, r1_abs_x, n1_abs_r, n1_abs_x;
    // Stage 2: (|d| * 433 + 250) / 4
    logic signed [15:0] r2_base_r, r2_base_x;
    logic               r2_neg_r, r2_neg_x;
    logic [22:0]        r2_n_r, r2_n_x, n2_n_r, n2_n_x;
    // Stage 3: quotient estimate by reciprocal
    logic signed [15:0] r3_base_r, r3_base_x;
    logic               r3_neg_r, r3_neg_x;
    logic [22:0]        r3_n_r, r3_n_x;
    logic [15:0]        r3_q0_r, r3_q0_x, n3_q0_r, n3_q0_x;
    // Stage 4: corrected quotient
    logic signed [15:0] r4_base_r, r4_base_x;
    logic               r4_neg_r, r4_neg_x;
    logic [15:0]        r4_q_r, r4_q_x, n4_q_r, n4_q_x;
    // Stage 5: wrapped phasor
    logic signed [15:0] r5_real, r5_imag, n5_real, n5_imag;
    // Stage 6: squares
    logic signed [15:0] r6_real, r6_imag;
    logic [31:0]        r6_sq_r, r6_sq_x, n6_sq_r, n6_sq_x;
    // Root stages: index 0 holds the squared sum
    logic [16:0]        r_sq_rem  [0:SQRT_STEPS];
    logic [15:0]        r_sq_root [0:SQRT_STEPS];
    logic [31:0]        r_sq_rad  [0:SQRT_STEPS];
    logic signed [15:0] r_sq_real [0:SQRT_STEPS];
    logic signed [15:0] r_sq_imag [0:SQRT_STEPS];
    logic [16:0]        n_sq_rem  [1:SQRT_STEPS];
    logic [15:0]        n_sq_root [1:SQRT_STEPS];
    logic [31:0]        n_sq_rad  [1:SQRT_STEPS];

    // Hold everything while a finished item waits on the receiver
    assign w_adv   = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // Form base terms and difference terms for the selected input set
    always_comb begin
        logic signed [15:0] ra, xa, rb, xb, rc, xc;
        logic signed [16:0] b_r, b_x, d_r, d_x;
        ra = i_first_real;
        xa = i_first_imag;
        rb = i_second_real;
        xb = i_second_imag;
        rc = i_third_real;
        xc = i_third_imag;
        case (t_op'(i_operation))
            OP_LINE: begin
                b_r = sx17(ra) + half_tz(sx17(rb));
                d_r = sx17(xb);
                b_x = sx17(xa) + half_tz(sx17(xb));
                d_x = -sx17(rb);
            end
            default: begin
                if (t_op'(i_operation) == OP_DERIVED) begin
                    rb = 16'(-(sx17(ra) + sx17(rc)));
                    xb = 16'(-(sx17(xa) + sx17(xc)));
                end
                b_r = sx17(ra) - half_tz(sx17(rb) + sx17(rc));
                d_r = sx17(xb) - sx17(xc);
                b_x = sx17(xa) - half_tz(sx17(xc) + sx17(xb));
                d_x = sx17(rc) - sx17(rb);
            end
        endcase
        n1_base_r = b_r[15:0];
        n1_base_x = b_x[15:0];
        n1_neg_r  = d_r[16];
        n1_neg_x  = d_x[16];
        n1_abs_r  = d_r[16] ? 16'(-d_r) : 16'(d_r);
        n1_abs_x  = d_x[16] ? 16'(-d_x) : 16'(d_x);
    end

    // Scale by 433 and add the rounding half, dropping the factor four of 500
    always_comb begin
        logic [24:0] p_r, p_x;
        p_r    = 25'(r1_abs_r) * 25'(K_NUM) + 25'(K_HALF);
        p_x    = 25'(r1_abs_x) * 25'(K_NUM) + 25'(K_HALF);
        n2_n_r = p_r[24:2];
        n2_n_x = p_x[24:2];
    end

    // Estimate the quotient by 125; it is low by at most one
    always_comb begin
        logic [46:0] m_r, m_x;
        m_r     = 47'(r2_n_r) * 47'(RECIP_M);
        m_x     = 47'(r2_n_x) * 47'(RECIP_M);
        n3_q0_r = m_r[RECIP_SHIFT +: 16];
        n3_q0_x = m_x[RECIP_SHIFT +: 16];
    end

    // Correct the estimate with one compare against the remainder
    always_comb begin
        logic [22:0] rem_r, rem_x;
        rem_r  = r3_n_r - 23'(r3_q0_r) * 23'(K_DIV4);
        rem_x  = r3_n_x - 23'(r3_q0_x) * 23'(K_DIV4);
        n4_q_r = r3_q0_r + 16'(rem_r >= 23'(K_DIV4));
        n4_q_x = r3_q0_x + 16'(rem_x >= 23'(K_DIV4));
    end

    // Apply the sign and add to the base, wrapping to 16 bits
    always_comb begin
        n5_real = r4_base_r + (r4_neg_r ? -$signed(r4_q_r) : $signed(r4_q_r));
        n5_imag = r4_base_x + (r4_neg_x ? -$signed(r4_q_x) : $signed(r4_q_x));
    end

    // Square both parts
    always_comb begin
        logic signed [31:0] s_r, s_x;
        s_r     = 32'(r5_real) * 32'(r5_real);
        s_x     = 32'(r5_imag) * 32'(r5_imag);
        n6_sq_r = s_r;
        n6_sq_x = s_x;
    end

    // Advance the arithmetic stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_base_r <= n1_base_r;
            r1_base_x <= n1_base_x;
            r1_neg_r  <= n1_neg_r;
            r1_neg_x  <= n1_neg_x;
            r1_abs_r  <= n1_abs_r;
            r1_abs_x  <= n1_abs_x;

            r2_base_r <= r1_base_r;
            r2_base_x <= r1_base_x;
            r2_neg_r  <= r1_neg_r;
            r2_neg_x  <= r1_neg_x;
            r2_n_r    <= n2_n_r;
            r2_n_x    <= n2_n_x;

            r3_base_r <= r2_base_r;
            r3_base_x <= r2_base_x;
            r3_neg_r  <= r2_neg_r;
            r3_neg_x  <= r2_neg_x;
            r3_n_r    <= r2_n_r;
            r3_n_x    <= r2_n_x;
            r3_q0_r   <= n3_q0_r;
            r3_q0_x   <= n3_q0_x;

            r4_base_r <= r3_base_r;
            r4_base_x <= r3_base_x;
            r4_neg_r  <= r3_neg_r;
            r4_neg_x  <= r3_neg_x;
            r4_q_r    <= n4_q_r;
            r4_q_x    <= n4_q_x;

            r5_real   <= n5_real;
            r5_imag   <= n5_imag;

            r6_real   <= r5_real;
            r6_imag   <= r5_imag;
            r6_sq_r   <= n6_sq_r;
            r6_sq_x   <= n6_sq_x;

            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_rad[0]  <= r6_sq_r + r6_sq_x;
            r_sq_real[0] <= r6_real;
            r_sq_imag[0] <= r6_imag;
        end
    end

    // Restoring square root, one result bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        logic [18:0] w_cur, w_trial;
        logic        w_take;

        always_comb begin
            w_cur          = {r_sq_rem[j], r_sq_rad[j][31:30]};
            w_trial        = {1'b0, r_sq_root[j], 2'b01};
            w_take         = (w_cur >= w_trial);
            n_sq_rem[j+1]  = w_take ? 17'(w_cur - w_trial) : 17'(w_cur);
            n_sq_root[j+1] = {r_sq_root[j][14:0], w_take};
            n_sq_rad[j+1]  = {r_sq_rad[j][29:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_rem[j+1]  <= n_sq_rem[j+1];
                r_sq_root[j+1] <= n_sq_root[j+1];
                r_sq_rad[j+1]  <= n_sq_rad[j+1];
                r_sq_real[j+1] <= r_sq_real[j];
                r_sq_imag[j+1] <= r_sq_imag[j];
            end
        end
    end

    assign o_valid     = r_vld[PIPE_DEPTH-1];
    assign o_neg_real  = r_sq_real[SQRT_STEPS];
    assign o_neg_imag  = r_sq_imag[SQRT_STEPS];
    assign o_magnitude = r_sq_root[SQRT_STEPS];

    // Bounds of the root against the delivered phasor
    logic signed [31:0] w_chk_r2, w_chk_x2;
    logic [16:0]        w_chk_m1;
    logic [33:0]        w_chk_sum, w_mag_lo, w_mag_hi;

    assign w_chk_r2  = 32'(o_neg_real) * 32'(o_neg_real);
    assign w_chk_x2  = 32'(o_neg_imag) * 32'(o_neg_imag);
    assign w_chk_sum = 34'(unsigned'(w_chk_r2)) + 34'(unsigned'(w_chk_x2));
    assign w_chk_m1  = 17'(o_magnitude) + 17'd1;
    assign w_mag_lo  = 34'(o_magnitude) * 34'(o_magnitude);
    assign w_mag_hi  = 34'(w_chk_m1) * 34'(w_chk_m1);

    `NSM_ASSERT_IMP(a_root_bounds, o_valid, (w_mag_lo <= w_chk_sum) && (w_chk_sum < w_mag_hi))
    `NSM_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall)
    `NSM_ASSERT_NXT(a_reset_empty, !i_rst_n, !o_valid && !o_stall)

endmodule
